[hw/rtl/block_bitmap_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Short forms for the concurrent checks used in the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Sizes, request and status codes, state encoding and map helper functions.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS    = 4096;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = MAX_BLOCKS / MAP_WORD_BITS;
  localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
  localparam int BLOCK_W       = 12;
  localparam int COUNT_W       = 13;
  localparam int CFG_W         = 13;

  localparam logic [COUNT_W-1:0]    COUNT_MAX = '1;
  localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(MAP_WORDS - 1);

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;
  typedef logic [WORD_IDX_W-1:0]    word_idx_t;
  typedef logic [BIT_IDX_W-1:0]     bit_idx_t;

  // Configuration register indexes.
  localparam logic CFG_TOTAL_BLOCKS    = 1'b0;
  localparam logic CFG_RESERVED_BLOCKS = 1'b1;

  typedef enum logic [1:0] {
    REQ_FORMAT = 2'd0,
    REQ_ALLOC  = 2'd1,
    REQ_FREE   = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_NO_FREE      = 2'd1,
    STAT_OUT_OF_RANGE = 2'd2,
    STAT_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FORMAT,
    ST_SCAN,
    ST_ACCESS
  } state_t;

  // Read request to the map store.
  typedef struct packed {
    logic      en;
    word_idx_t addr;
  } map_rd_t;

  // Write request to the map store.
  typedef struct packed {
    logic      en;
    word_idx_t addr;
    map_word_t data;
  } map_wr_t;

  // Bits of map word idx that lie below block count n.
  function automatic map_word_t mask_below(word_idx_t idx, logic [COUNT_W-1:0] n);
    logic [COUNT_W-BIT_IDX_W-1:0] n_words;
    map_word_t                    m;
    n_words = n[COUNT_W-1:BIT_IDX_W];
    if ((COUNT_W-BIT_IDX_W)'(idx) < n_words) begin
      m = '1;
    end else if ((COUNT_W-BIT_IDX_W)'(idx) == n_words) begin
      m = (map_word_t'(1) << n[BIT_IDX_W-1:0]) - map_word_t'(1);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  // Position of the lowest set bit; zero when none is set.
  function automatic bit_idx_t lowest_set(map_word_t v);
    bit_idx_t pos;
    pos = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_IDX_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

[hw/rtl/block_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit block allocator over a one-bit-per-block occupancy map held in
// a 64 x 64-bit memory, with a free-block counter.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start / busy         req_type, block_number
//  result    done (one cycle)     status, block_out, bit_value, free_count_out
//  config    cfg_we               cfg_index, cfg_data
//
//  Format writes every map word once.
//  Allocate reads one map word per cycle from word 0 until a clear bit is
//  found or the last word is read; none if the free count or limit is zero.
//  Free and read take one memory read; none when out of range.
//  Reset (rst, synchronous) clears the map row valid bits and the free count.
//  done is high for one cycle per request; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module block_bitmap_allocator
  import bba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [BLOCK_W-1:0] block_number,
  output logic               done,
  output logic [1:0]         status,
  output logic [BLOCK_W-1:0] block_out,
  output logic               bit_value,
  output logic [COUNT_W-1:0] free_count_out,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  `include "block_bitmap_allocator_assert.svh"

  state_t               state, state_next;
  word_idx_t            widx, widx_next;
  logic [COUNT_W-1:0]   lim_q, lim_next;
  logic [COUNT_W-1:0]   res_q, res_next;
  logic [BLOCK_W-1:0]   blk_q, blk_next;
  req_t                 req_q, req_next;
  logic [COUNT_W-1:0]   free_count, free_count_next;
  logic                 done_next;
  logic [1:0]           status_next;
  logic [BLOCK_W-1:0]   block_out_next;
  logic                 bit_value_next;
  logic [CFG_W-1:0]     total_blocks;
  logic [CFG_W-1:0]     reserved_blocks;

  logic [COUNT_W-1:0]   lim_now;
  logic [COUNT_W-1:0]   lim_m1;
  word_idx_t            last_idx;
  req_t                 req_in;
  map_word_t            rd_data;
  map_word_t            cand;
  bit_idx_t             cand_pos;
  logic                 cur_bit;
  map_rd_t              rd_req;
  map_wr_t              wr_req;

  // Occupancy map memory.
  bba_map_store u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_req  (rd_req),
    .rd_data (rd_data),
    .wr_req  (wr_req)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks    <= CFG_W'(MAX_BLOCKS);
      reserved_blocks <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOTAL_BLOCKS:    total_blocks    <= cfg_data;
        CFG_RESERVED_BLOCKS: reserved_blocks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block limit, saturated to the map size, and the last word to scan.
  assign lim_now  = (total_blocks > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : total_blocks;
  assign lim_m1   = lim_q - COUNT_W'(1);
  assign last_idx = lim_m1[BLOCK_W-1:BIT_IDX_W];
  assign req_in   = req_t'(req_type);

  // Scan and access helpers on the word just read.
  assign cand     = ~rd_data & mask_below(widx, lim_q);
  assign cand_pos = lowest_set(cand);
  assign cur_bit  = rd_data[blk_q[BIT_IDX_W-1:0]];

  assign busy           = (state != ST_IDLE);
  assign free_count_out = free_count;

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      free_count <= '0;
    end else begin
      state      <= state_next;
      done       <= done_next;
      free_count <= free_count_next;
    end
  end

  // Request payload and result payload registers.
  always_ff @(posedge clk) begin
    widx      <= widx_next;
    lim_q     <= lim_next;
    res_q     <= res_next;
    blk_q     <= blk_next;
    req_q     <= req_next;
    status    <= status_next;
    block_out <= block_out_next;
    bit_value <= bit_value_next;
  end

  // Sequencer: next state, memory requests and results.
  always_comb begin
    state_next      = state;
    widx_next       = widx;
    lim_next        = lim_q;
    res_next        = res_q;
    blk_next        = blk_q;
    req_next        = req_q;
    free_count_next = free_count;
    done_next       = 1'b0;
    status_next     = status;
    block_out_next  = block_out;
    bit_value_next  = bit_value;
    rd_req          = '0;
    wr_req          = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          lim_next       = lim_now;
          blk_next       = block_number;
          req_next       = req_in;
          status_next    = STAT_OK;
          block_out_next = '0;
          bit_value_next = 1'b0;
          widx_next      = '0;
          unique case (req_in)
            REQ_FORMAT: begin
              res_next   = (reserved_blocks < lim_now) ? reserved_blocks : lim_now;
              state_next = ST_FORMAT;
            end
            REQ_ALLOC: begin
              if (free_count == '0 || lim_now == '0) begin
                status_next = STAT_NO_FREE;
                done_next   = 1'b1;
              end else begin
                rd_req.en   = 1'b1;
                rd_req.addr = '0;
                state_next  = ST_SCAN;
              end
            end
            REQ_FREE, REQ_READ: begin
              block_out_next = block_number;
              if (COUNT_W'(block_number) >= lim_now) begin
                status_next = STAT_OUT_OF_RANGE;
                done_next   = 1'b1;
              end else begin
                rd_req.en   = 1'b1;
                rd_req.addr = block_number[BLOCK_W-1:BIT_IDX_W];
                state_next  = ST_ACCESS;
              end
            end
            default: ;
          endcase
        end
      end

      // Rewrite every map word with the reserved pattern.
      ST_FORMAT: begin
        wr_req.en   = 1'b1;
        wr_req.addr = widx;
        wr_req.data = mask_below(widx, res_q);
        widx_next   = widx + word_idx_t'(1);
        if (widx == WORD_LAST) begin
          free_count_next = lim_q - res_q;
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end
      end

      // Check the word read last cycle while fetching the next one.
      ST_SCAN: begin
        if (cand != '0) begin
          wr_req.en       = 1'b1;
          wr_req.addr     = widx;
          wr_req.data     = rd_data | (map_word_t'(1) << cand_pos);
          block_out_next  = {widx, cand_pos};
          free_count_next = free_count - COUNT_W'(1);
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end else if (widx == last_idx) begin
          status_next = STAT_NO_FREE;
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          widx_next   = widx + word_idx_t'(1);
          rd_req.en   = 1'b1;
          rd_req.addr = widx + word_idx_t'(1);
        end
      end

      // Single-bit read, or clear for a free request.
      ST_ACCESS: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        if (req_q == REQ_READ) begin
          bit_value_next = cur_bit;
        end else if (!cur_bit) begin
          status_next = STAT_ALREADY_FREE;
        end else begin
          wr_req.en   = 1'b1;
          wr_req.addr = blk_q[BLOCK_W-1:BIT_IDX_W];
          wr_req.data = rd_data & ~(map_word_t'(1) << blk_q[BIT_IDX_W-1:0]);
          if (free_count != COUNT_MAX) begin
            free_count_next = free_count + COUNT_W'(1);
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Checks on the sequencer.
  `BBA_ASSERT_SAME(a_done_when_idle, done, !busy, "result issued while a request is in progress")
  `BBA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done,
                   "accepted request neither in progress nor finished")
  `BBA_ASSERT_SAME(a_write_when_busy, wr_req.en, busy, "map written while idle")
  `BBA_ASSERT_SAME(a_no_free_block_zero, done && status == STAT_NO_FREE, block_out == '0,
                   "failed allocation returned a block number")

endmodule

[hw/rtl/bba_map_store.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator map store
// Occupancy map memory, one word per row, with a registered read and a
// valid bit per row so that rows never written since reset read as zero.
// ----------------------------------------------------------------------------
module bba_map_store
  import bba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  map_rd_t   rd_req,
  output map_word_t rd_data,
  input  map_wr_t   wr_req
);

  map_word_t              mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]   row_valid;
  map_word_t              mem_q;
  logic                   valid_q;

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      mem_q <= mem[rd_req.addr];
    end
  end

  // Row valid bits, cleared by reset and set by any write to the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (wr_req.en) begin
        row_valid[wr_req.addr] <= 1'b1;
      end
      if (rd_req.en) begin
        valid_q <= row_valid[rd_req.addr];
      end
    end
  end

  // A row that was never written reads as an empty map word.
  assign rd_data = valid_q ? mem_q : '0;

endmodule

[tb/block_bitmap_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block bitmap allocator testbench
// Drives format, allocate, free and read requests through the start/busy
// port, mirrors the occupancy map and free count in a behavioural copy, and
// checks each result against it or a row's pinned values. A directed table
// covers corner cases, then random phases vary block limits and idling.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_test;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int DRAIN_CYCLES    = 70;
  localparam int MAX_GAP         = 80;

  // One result as the block reports it.
  typedef struct packed {
    status_t              st;
    logic [BLOCK_W-1:0]   blk;
    logic                 bitv;
    logic [COUNT_W-1:0]   cnt;
  } alloc_result_t;

  // One row of the directed table: a register write or a request.
  typedef struct packed {
    logic                 is_cfg;
    logic                 cfg_idx;
    logic [CFG_W-1:0]     cfg_val;
    req_t                 req;
    logic [BLOCK_W-1:0]   blk;
    logic                 pinned;
    alloc_result_t        exp;
  } stim_row_t;

  // Register settings and sender idling for one random phase.
  typedef struct packed {
    logic [CFG_W-1:0]     total;
    logic [CFG_W-1:0]     reserved;
    logic [6:0]           idle_pct;
  } phase_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  req_t               req_type = REQ_FORMAT;
  logic [BLOCK_W-1:0] block_number = '0;
  logic               done;
  logic [1:0]         status;
  logic [BLOCK_W-1:0] block_out;
  logic               bit_value;
  logic [COUNT_W-1:0] free_count_out;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_TOTAL_BLOCKS;
  logic [CFG_W-1:0]   cfg_data = '0;

  // Behavioural copy of the allocator state and its registers.
  bit                 occupied [MAX_BLOCKS];
  logic [COUNT_W-1:0] free_blocks = '0;
  logic [CFG_W-1:0]   total_reg = CFG_W'(4096);
  logic [CFG_W-1:0]   reserved_reg = CFG_W'(1);

  alloc_result_t      pending_results [$];
  logic [BLOCK_W-1:0] held_blocks [$];
  int                 accept_count = 0;
  int                 cycle_count = 0;
  int                 errors = 0;
  logic               pinned_valid = 1'b0;
  alloc_result_t      pinned_exp;

  block_bitmap_allocator u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .block_number   (block_number),
    .done           (done),
    .status         (status),
    .block_out      (block_out),
    .bit_value      (bit_value),
    .free_count_out (free_count_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Block limit as the allocator sees it: total_blocks capped at the map size.
  function automatic logic [COUNT_W-1:0] block_limit();
    return (total_reg > CFG_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : total_reg;
  endfunction

  // Applies one request to the copy of the map and returns the result.
  task automatic apply_request(input req_t r, input logic [BLOCK_W-1:0] b,
                               output alloc_result_t res);
    logic [COUNT_W-1:0] lim;
    logic [COUNT_W-1:0] rsv;
    int                 idx;
    bit                 found;
    lim   = block_limit();
    found = 1'b0;
    idx   = 0;
    res.st   = STAT_OK;
    res.blk  = '0;
    res.bitv = 1'b0;
    case (r)
      REQ_FORMAT: begin
        rsv = (reserved_reg < lim) ? reserved_reg : lim;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
          occupied[i] = (i < rsv);
        end
        free_blocks = lim - rsv;
      end
      REQ_ALLOC: begin
        // First fit, but only when the count says something is free.
        if (free_blocks != '0) begin
          for (int i = 0; i < lim && !found; i++) begin
            if (!occupied[i]) begin
              found = 1'b1;
              idx   = i;
            end
          end
        end
        if (found) begin
          occupied[idx] = 1'b1;
          free_blocks   = free_blocks - 1'b1;
          res.blk       = BLOCK_W'(idx);
        end else begin
          res.st = STAT_NO_FREE;
        end
      end
      REQ_FREE: begin
        res.blk = b;
        if (b >= lim) begin
          res.st = STAT_OUT_OF_RANGE;
        end else if (!occupied[b]) begin
          res.st = STAT_ALREADY_FREE;
        end else begin
          occupied[b] = 1'b0;
          if (free_blocks != COUNT_MAX) begin
            free_blocks = free_blocks + 1'b1;
          end
        end
      end
      default: begin
        res.blk = b;
        if (b >= lim) begin
          res.st = STAT_OUT_OF_RANGE;
        end else begin
          res.bitv = occupied[b];
        end
      end
    endcase
    res.cnt = free_blocks;
  endtask

  // Results are checked, requests predicted and register writes mirrored here.
  always @(posedge clk) begin : monitor
    alloc_result_t want;
    alloc_result_t got;
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("block_bitmap_allocator_test failed");
      $finish;
    end
    if (!rst) begin
      // A result leaves the queue before a request accepted at this edge joins it.
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: status %0d, block %0d",
                 status, block_out);
          errors = errors + 1;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            errors = errors + 1;
          end
          if (block_out !== want.blk) begin
            $error("block_out: expected %0d, got %0d", want.blk, block_out);
            errors = errors + 1;
          end
          if (bit_value !== want.bitv) begin
            $error("bit_value: expected %0d, got %0d", want.bitv, bit_value);
            errors = errors + 1;
          end
          if (free_count_out !== want.cnt) begin
            $error("free_count_out: expected %0d, got %0d", want.cnt, free_count_out);
            errors = errors + 1;
          end
        end
      end
      if (start && busy === 1'b0) begin
        apply_request(req_type, block_number, got);
        if (req_type == REQ_FORMAT) begin
          held_blocks.delete();
        end else if (req_type == REQ_ALLOC && got.st == STAT_OK) begin
          held_blocks.push_back(got.blk);
        end
        pending_results.push_back(pinned_valid ? pinned_exp : got);
        accept_count = accept_count + 1;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_TOTAL_BLOCKS) begin
          total_reg = cfg_data;
        end else begin
          reserved_reg = cfg_data;
        end
      end
    end
  end

  // Presents one request and returns at the falling edge after it is taken.
  task automatic issue(input req_t r, input logic [BLOCK_W-1:0] b);
    int seen;
    seen = accept_count;
    start        <= 1'b1;
    req_type     <= r;
    block_number <= b;
    do @(negedge clk); while (accept_count == seen);
  endtask

  // Waits until every outstanding request has reported and the block is idle.
  task automatic wait_idle();
    while (pending_results.size() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic stim_row_t chk(input req_t r, input logic [BLOCK_W-1:0] b,
                                    input status_t st, input logic [BLOCK_W-1:0] bo,
                                    input logic bv, input logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row         = '0;
    row.req     = r;
    row.blk     = b;
    row.pinned  = 1'b1;
    row.exp.st  = st;
    row.exp.blk = bo;
    row.exp.bitv = bv;
    row.exp.cnt = cnt;
    return row;
  endfunction

  function automatic stim_row_t req_only(input req_t r, input logic [BLOCK_W-1:0] b);
    stim_row_t row;
    row     = '0;
    row.req = r;
    row.blk = b;
    return row;
  endfunction

  function automatic stim_row_t reg_wr(input logic idx, input logic [CFG_W-1:0] val);
    stim_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  // Block number for a free or read: mostly in range, some at the limit,
  // the rest anywhere in the field.
  function automatic logic [BLOCK_W-1:0] pick_block();
    logic [COUNT_W-1:0] lim;
    int                 p;
    lim = block_limit();
    p   = $urandom_range(99);
    if (p < 35 || lim == '0) begin
      return BLOCK_W'($urandom_range(MAX_BLOCKS - 1, 0));
    end else if (p < 45 && lim < COUNT_W'(MAX_BLOCKS)) begin
      return BLOCK_W'(lim);
    end
    return BLOCK_W'($urandom_range(int'(lim) - 1, 0));
  endfunction

  // Mostly allocate and free of held blocks, with reads, formats and strays.
  task automatic next_random(output req_t r, output logic [BLOCK_W-1:0] b);
    int p;
    int idx;
    p = $urandom_range(99);
    b = BLOCK_W'($urandom);
    if (p < 3) begin
      r = REQ_FORMAT;
    end else if (p < 45) begin
      r = REQ_ALLOC;
    end else if (p < 75) begin
      r = REQ_FREE;
      if (held_blocks.size() != 0 && $urandom_range(99) < 75) begin
        idx = $urandom_range(held_blocks.size() - 1, 0);
        b   = held_blocks[idx];
        held_blocks.delete(idx);
      end else begin
        b = pick_block();
      end
    end else begin
      r = REQ_READ;
      if (held_blocks.size() != 0 && $urandom_range(99) < 40) begin
        b = held_blocks[$urandom_range(held_blocks.size() - 1, 0)];
      end else begin
        b = pick_block();
      end
    end
  endtask

  initial begin : stimulus
    stim_row_t          directed_rows [$];
    phase_t             phases [4];
    req_t               r;
    logic [BLOCK_W-1:0] b;

    // Corner cases: before any format, single block, no blocks, limits above
    // the map size, reserved above the limit, exhaustion with a nonzero count.
    directed_rows = '{
      chk(REQ_ALLOC, 12'hFFF, STAT_NO_FREE, 12'd0, 1'b0, 13'd0),
      chk(REQ_READ, 12'd0, STAT_OK, 12'd0, 1'b0, 13'd0),
      chk(REQ_READ, 12'd4095, STAT_OK, 12'd4095, 1'b0, 13'd0),
      chk(REQ_FREE, 12'd5, STAT_ALREADY_FREE, 12'd5, 1'b0, 13'd0),
      chk(REQ_FORMAT, 12'hABC, STAT_OK, 12'd0, 1'b0, 13'd4095),
      chk(REQ_ALLOC, 12'd0, STAT_OK, 12'd1, 1'b0, 13'd4094),
      chk(REQ_READ, 12'd0, STAT_OK, 12'd0, 1'b1, 13'd4094),
      chk(REQ_FREE, 12'd1, STAT_OK, 12'd1, 1'b0, 13'd4095),
      chk(REQ_FREE, 12'd1, STAT_ALREADY_FREE, 12'd1, 1'b0, 13'd4095),
      req_only(REQ_ALLOC, 12'd7),
      req_only(REQ_FREE, 12'd0),
      reg_wr(CFG_TOTAL_BLOCKS, 13'd1),
      reg_wr(CFG_RESERVED_BLOCKS, 13'd0),
      chk(REQ_FORMAT, 12'd0, STAT_OK, 12'd0, 1'b0, 13'd1),
      chk(REQ_READ, 12'd1, STAT_OUT_OF_RANGE, 12'd1, 1'b0, 13'd1),
      chk(REQ_FREE, 12'd4095, STAT_OUT_OF_RANGE, 12'd4095, 1'b0, 13'd1),
      chk(REQ_ALLOC, 12'd0, STAT_OK, 12'd0, 1'b0, 13'd0),
      chk(REQ_ALLOC, 12'd0, STAT_NO_FREE, 12'd0, 1'b0, 13'd0),
      reg_wr(CFG_TOTAL_BLOCKS, 13'd0),
      chk(REQ_READ, 12'd0, STAT_OUT_OF_RANGE, 12'd0, 1'b0, 13'd0),
      chk(REQ_FORMAT, 12'd0, STAT_OK, 12'd0, 1'b0, 13'd0),
      reg_wr(CFG_TOTAL_BLOCKS, 13'd8191),
      reg_wr(CFG_RESERVED_BLOCKS, 13'd8191),
      chk(REQ_FORMAT, 12'd0, STAT_OK, 12'd0, 1'b0, 13'd0),
      chk(REQ_READ, 12'd4095, STAT_OK, 12'd4095, 1'b1, 13'd0),
      chk(REQ_FREE, 12'd4095, STAT_OK, 12'd4095, 1'b0, 13'd1),
      chk(REQ_ALLOC, 12'd0, STAT_OK, 12'd4095, 1'b0, 13'd0),
      reg_wr(CFG_TOTAL_BLOCKS, 13'd4096),
      reg_wr(CFG_RESERVED_BLOCKS, 13'd0),
      chk(REQ_FORMAT, 12'd0, STAT_OK, 12'd0, 1'b0, 13'd4096),
      reg_wr(CFG_TOTAL_BLOCKS, 13'd1),
      chk(REQ_ALLOC, 12'd0, STAT_OK, 12'd0, 1'b0, 13'd4095),
      chk(REQ_ALLOC, 12'd0, STAT_NO_FREE, 12'd0, 1'b0, 13'd4095),
      reg_wr(CFG_TOTAL_BLOCKS, 13'd70),
      reg_wr(CFG_RESERVED_BLOCKS, 13'd100),
      chk(REQ_FORMAT, 12'd0, STAT_OK, 12'd0, 1'b0, 13'd0)
    };

    // The third phase limits the map to one word; this port has no stalling receiver.
    phases[0] = '{total: 13'd4096, reserved: 13'd1,    idle_pct: 7'd0};
    phases[1] = '{total: 13'd200,  reserved: 13'd3,    idle_pct: 7'd62};
    phases[2] = '{total: 13'd64,   reserved: 13'd0,    idle_pct: 7'd0};
    phases[3] = '{total: 13'd4096, reserved: 13'd4000, idle_pct: 7'd22};

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table, back to back.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        start <= 1'b0;
        wait_idle();
        write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      end else begin
        pinned_valid = directed_rows[i].pinned;
        pinned_exp   = directed_rows[i].exp;
        issue(directed_rows[i].req, directed_rows[i].blk);
      end
    end
    pinned_valid = 1'b0;

    // Random phases, each opened by a fresh format under new limits.
    foreach (phases[p]) begin
      start <= 1'b0;
      wait_idle();
      write_reg(CFG_TOTAL_BLOCKS, phases[p].total);
      write_reg(CFG_RESERVED_BLOCKS, phases[p].reserved);
      issue(REQ_FORMAT, BLOCK_W'($urandom));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < phases[p].idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(MAX_GAP, 1)) @(negedge clk);
        end
        next_random(r, b);
        issue(r, b);
      end
    end

    start <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("block_bitmap_allocator_test passed");
    end else begin
      $display("block_bitmap_allocator_test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_map_store.sv
hw/rtl/block_bitmap_allocator.sv
tb/block_bitmap_allocator_test.sv
